>>> rtl/core/oad_pkg.sv
// Package for the obstacle-avoiding drive state machine.
// Holds the state numbering, the motor setpoints and the distance bundle type.
// No dependencies.
package oad_pkg;

  localparam int DistW  = 8;
  localparam int DriveW = 11;
  localparam int ModeW  = 5;

  typedef logic [ModeW-1:0]          mode_t;
  typedef logic signed [DriveW-1:0]  drive_t;

  // Action states are even; each holding state is its action plus one.
  localparam mode_t MODE_WAIT     = 5'd0;
  localparam mode_t MODE_TRACE    = 5'd2;
  localparam mode_t MODE_ADVANCE  = 5'd4;
  localparam mode_t MODE_SLIGHT_R = 5'd6;
  localparam mode_t MODE_SLIGHT_L = 5'd8;
  localparam mode_t MODE_TURN_L   = 5'd10;
  localparam mode_t MODE_TURN_R   = 5'd12;
  localparam mode_t MODE_SPIN_L   = 5'd14;
  localparam mode_t MODE_SPIN_R   = 5'd16;
  localparam mode_t MODE_LAST     = 5'd17;

  // Motor setpoints in tenths of a percent.
  localparam drive_t DRV_ZERO       = 11'sd0;
  localparam drive_t DRV_TRACE_R    = -11'sd390;
  localparam drive_t DRV_TRACE_L    = 11'sd426;
  localparam drive_t DRV_ADVANCE_R  = -11'sd250;
  localparam drive_t DRV_ADVANCE_L  = 11'sd265;
  localparam drive_t DRV_SLOW_NEG   = -11'sd150;
  localparam drive_t DRV_SLOW_POS   = 11'sd150;
  localparam drive_t DRV_CRAWL_NEG  = -11'sd100;
  localparam drive_t DRV_CRAWL_POS  = 11'sd100;

  typedef struct packed {
    logic [DistW-1:0] left_side;
    logic [DistW-1:0] right_side;
    logic [DistW-1:0] left;
    logic [DistW-1:0] center;
    logic [DistW-1:0] right;
  } dist_t;

endpackage

>>> rtl/core/oad_classify.sv
// Obstacle classifier: picks the next action from the five distances.
// Purely combinational; depends on oad_pkg.
module oad_classify
  import oad_pkg::*;
(
  input  dist_t ranges,
  input  logic  parity,
  output mode_t next_action
);

  mode_t spin_action;

  assign spin_action = parity ? MODE_SPIN_R : MODE_SPIN_L;

  // The first matching class wins, so the order of the arms matters.
  always_comb begin
    priority if (ranges.right < 8'd25 && ranges.left < 8'd25) begin
      next_action = spin_action;
    end else if (ranges.right < 8'd30 && ranges.center > 8'd20 && ranges.left > 8'd30) begin
      next_action = MODE_TURN_L;
    end else if (ranges.right > 8'd30 && ranges.center > 8'd20 && ranges.left < 8'd30) begin
      next_action = MODE_TURN_R;
    end else if (ranges.center < 8'd30) begin
      next_action = spin_action;
    end else if (ranges.right_side < 8'd10 && ranges.left_side < 8'd10) begin
      next_action = (ranges.right_side < ranges.left_side) ? MODE_SLIGHT_R : MODE_SLIGHT_L;
    end else if (ranges.right_side < 8'd15) begin
      next_action = MODE_SLIGHT_R;
    end else if (ranges.left_side < 8'd15) begin
      next_action = MODE_SLIGHT_L;
    end else if (ranges.right < 8'd50 || ranges.center < 8'd60 || ranges.left < 8'd50 ||
                 ranges.left_side < 8'd40 || ranges.right_side < 8'd40) begin
      next_action = MODE_ADVANCE;
    end else begin
      next_action = MODE_TRACE;
    end
  end

endmodule

>>> rtl/core/oad_core.sv
// State registers of the drive machine and their next-state logic.
// Depends on oad_pkg and oad_classify. The registers double as the result.
module oad_core
  import oad_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  logic   jack_present,
  input  dist_t  ranges,
  output drive_t right_setpoint,
  output drive_t left_setpoint,
  output logic   white_led,
  output logic   blue_led,
  output mode_t  robot_mode
);

  mode_t  mode_r, mode_nxt;
  logic   parity_r, parity_nxt;
  drive_t right_r, right_nxt;
  drive_t left_r, left_nxt;
  logic   white_r, white_nxt;
  logic   blue_r, blue_nxt;
  mode_t  next_action;

  oad_classify u_classify (
    .ranges      (ranges),
    .parity      (parity_r),
    .next_action (next_action)
  );

  always_comb begin
    mode_nxt   = mode_r;
    parity_nxt = parity_r;
    right_nxt  = right_r;
    left_nxt   = left_r;
    white_nxt  = white_r;
    blue_nxt   = blue_r;
    if (!jack_present) begin
      right_nxt = DRV_ZERO;
      left_nxt  = DRV_ZERO;
      white_nxt = 1'b1;
      blue_nxt  = 1'b0;
      mode_nxt  = MODE_WAIT;
    end else if (mode_r == MODE_WAIT) begin
      // Leaving waiting goes straight to the chosen action, with no hold state between.
      right_nxt = DRV_ZERO;
      left_nxt  = DRV_ZERO;
      mode_nxt  = next_action;
    end else if (mode_r <= MODE_LAST && mode_r[0]) begin
      // Do not restart the action that is already being held.
      if (next_action + 5'd1 != mode_r) begin
        mode_nxt = next_action;
      end
    end else begin
      unique case (mode_r)
        MODE_TRACE: begin
          right_nxt = DRV_TRACE_R;
          left_nxt  = DRV_TRACE_L;
          white_nxt = 1'b0;
          blue_nxt  = 1'b1;
        end
        MODE_ADVANCE: begin
          right_nxt  = DRV_ADVANCE_R;
          left_nxt   = DRV_ADVANCE_L;
          white_nxt  = 1'b0;
          blue_nxt   = 1'b0;
          parity_nxt = ~parity_r;
        end
        MODE_SLIGHT_R: begin
          right_nxt = DRV_SLOW_NEG;
          left_nxt  = DRV_CRAWL_POS;
          white_nxt = 1'b0;
          blue_nxt  = 1'b0;
        end
        MODE_SLIGHT_L: begin
          right_nxt = DRV_CRAWL_NEG;
          left_nxt  = DRV_SLOW_POS;
          white_nxt = 1'b0;
          blue_nxt  = 1'b0;
        end
        MODE_TURN_L: begin
          right_nxt = DRV_ZERO;
          left_nxt  = DRV_SLOW_POS;
          white_nxt = 1'b0;
          blue_nxt  = 1'b0;
        end
        MODE_TURN_R: begin
          right_nxt = DRV_SLOW_NEG;
          left_nxt  = DRV_ZERO;
          white_nxt = 1'b0;
          blue_nxt  = 1'b0;
        end
        MODE_SPIN_L: begin
          right_nxt = DRV_CRAWL_NEG;
          left_nxt  = DRV_CRAWL_NEG;
          white_nxt = 1'b0;
          blue_nxt  = 1'b0;
        end
        MODE_SPIN_R: begin
          right_nxt = DRV_CRAWL_POS;
          left_nxt  = DRV_CRAWL_POS;
          white_nxt = 1'b0;
          blue_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
      if (mode_r <= MODE_LAST) begin
        mode_nxt = mode_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WAIT;
      parity_r <= 1'b0;
      right_r  <= DRV_ZERO;
      left_r   <= DRV_ZERO;
      white_r  <= 1'b0;
      blue_r   <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      parity_r <= parity_nxt;
      right_r  <= right_nxt;
      left_r   <= left_nxt;
      white_r  <= white_nxt;
      blue_r   <= blue_nxt;
    end
  end

  assign right_setpoint = right_r;
  assign left_setpoint  = left_r;
  assign white_led      = white_r;
  assign blue_led       = blue_r;
  assign robot_mode     = mode_r;

endmodule

>>> rtl/core/obstacle_avoid_drive_fsm_top.sv
// Channel  Dir  Width  Contents
// in_      in   48     jack flag and five distances, one transfer per control tick
// out_     out  32     held setpoints, LED levels and state number
//
// Each tick goes through the classifier and next-state logic into
// the state registers, which also serve as the result register.
// A new transfer is taken every cycle while the result is taken, or while no
// result is waiting. A stalled result holds and blocks only the input.
// Synchronous active-low reset returns to waiting with drives and LEDs off.
// Top level of the obstacle-avoiding drive machine; depends on oad_pkg and oad_core.
module obstacle_avoid_drive_fsm_top
  import oad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] jack_present, [8:1] dist_right, [16:9] dist_center, [24:17] dist_left,
  // [32:25] dist_right_side, [40:33] dist_left_side, [47:41] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [10:0] right_setpoint, [21:11] left_setpoint, [22] white_led,
  // [23] blue_led, [28:24] robot_mode, [31:29] zero
  output logic [31:0] out_tdata
);

  logic   out_valid_r;
  logic   step;
  dist_t  ranges;
  drive_t right_setpoint;
  drive_t left_setpoint;
  logic   white_led;
  logic   blue_led;
  mode_t  robot_mode;

  assign in_tready = ~out_valid_r | out_tready;
  assign step      = in_tvalid & in_tready;

  assign ranges.right      = in_tdata[8:1];
  assign ranges.center     = in_tdata[16:9];
  assign ranges.left       = in_tdata[24:17];
  assign ranges.right_side = in_tdata[32:25];
  assign ranges.left_side  = in_tdata[40:33];

  oad_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .jack_present   (in_tdata[0]),
    .ranges         (ranges),
    .right_setpoint (right_setpoint),
    .left_setpoint  (left_setpoint),
    .white_led      (white_led),
    .blue_led       (blue_led),
    .robot_mode     (robot_mode)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, robot_mode, blue_led, white_led,
                       left_setpoint, right_setpoint};

endmodule
